// File: rtl/core/ckh_pkg.sv
package ckh_pkg;

  localparam int unsigned KMER_W      = 62;
  localparam int unsigned KLEN_W      = 5;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [KLEN_W-1:0] MAX_K   = 5'd31;
  localparam logic [KLEN_W-1:0] K_RESET = 5'd31;

  localparam logic [7:0] CHAR_NL = 8'h0A;

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_SEQ    = 2'd1;

  localparam logic [2:0] CODE_BAD = 3'd4;

  typedef struct packed {
    logic [KMER_W-1:0] kmer;
    logic [KMER_W-1:0] mask;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [2:0] base_code(input logic [7:0] b);
    logic [2:0] c;
    c = CODE_BAD;
    if (b inside {8'h41, 8'h61}) c = 3'd0;
    else if (b inside {8'h43, 8'h63}) c = 3'd1;
    else if (b inside {8'h47, 8'h67}) c = 3'd2;
    else if (b inside {8'h54, 8'h74, 8'h55, 8'h75}) c = 3'd3;
    return c;
  endfunction

endpackage

// File: rtl/core/ckh_front.sv
module ckh_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ckh_pkg::KLEN_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_text_byte,
  input  logic                           in_end_of_buffer,
  input  ckh_pkg::q_status_t             q_stat,
  output logic                           push_valid,
  output ckh_pkg::entry_t                push_entry
);

  localparam int unsigned KW = ckh_pkg::KMER_W;

  logic [ckh_pkg::KLEN_W-1:0] klen_r, klen_nxt;
  logic [KW-1:0]              fwd_r, fwd_nxt;
  logic [KW-1:0]              rev_r, rev_nxt;
  logic [ckh_pkg::KLEN_W-1:0] run_r, run_nxt;
  logic [1:0]                 phase_r, phase_nxt;

  logic [ckh_pkg::KLEN_W-1:0] keff;
  logic [5:0]                 shamt;
  logic [5:0]                 top;
  logic [KW-1:0]              mask;
  logic [2:0]                 code;
  logic [KW-1:0]              fwd_shift;
  logic [KW-1:0]              rev_shift;
  logic [ckh_pkg::KLEN_W-1:0] run_inc;
  logic                       accept;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_stat.full;
  assign accept    = in_valid && !in_stall;

  always_comb begin
    if (klen_r == '0) begin
      keff = ckh_pkg::KLEN_W'(1);
    end else if (klen_r > ckh_pkg::MAX_K) begin
      keff = ckh_pkg::MAX_K;
    end else begin
      keff = klen_r;
    end
  end

  assign shamt     = {keff, 1'b0};
  assign top       = shamt - 6'd2;
  assign mask      = ~({KW{1'b1}} << shamt);
  assign code      = ckh_pkg::base_code(in_text_byte);
  assign fwd_shift = ((fwd_r << 2) | {{(KW-2){1'b0}}, code[1:0]}) & mask;
  assign rev_shift = ((rev_r >> 2) | ({{(KW-2){1'b0}}, 2'd3 - code[1:0]} << top)) & mask;
  assign run_inc   = (run_r < keff) ? run_r + 1'b1 : keff;

  always_comb begin
    klen_nxt   = klen_r;
    fwd_nxt    = fwd_r;
    rev_nxt    = rev_r;
    run_nxt    = run_r;
    phase_nxt  = phase_r;
    push_valid = 1'b0;
    push_entry.kmer = (fwd_shift < rev_shift) ? fwd_shift : rev_shift;
    push_entry.mask = mask;

    if (cfg_valid && cfg_ready) begin
      klen_nxt = cfg_data;
    end

    if (accept) begin
      if (in_text_byte == ckh_pkg::CHAR_NL) begin
        if (phase_r == ckh_pkg::PH_SEQ) begin
          fwd_nxt = '0;
          rev_nxt = '0;
          run_nxt = '0;
        end
        phase_nxt = phase_r + 2'd1;
      end else if (phase_r == ckh_pkg::PH_SEQ) begin
        if (code != ckh_pkg::CODE_BAD) begin
          fwd_nxt    = fwd_shift;
          rev_nxt    = rev_shift;
          run_nxt    = run_inc;
          push_valid = (run_inc == keff);
        end else begin
          fwd_nxt = '0;
          rev_nxt = '0;
          run_nxt = '0;
        end
      end
      // end of buffer clears the k-mer state and returns to the header phase after the byte is handled
      if (in_end_of_buffer) begin
        fwd_nxt   = '0;
        rev_nxt   = '0;
        run_nxt   = '0;
        phase_nxt = ckh_pkg::PH_HEADER;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      klen_r  <= ckh_pkg::K_RESET;
      fwd_r   <= '0;
      rev_r   <= '0;
      run_r   <= '0;
      phase_r <= ckh_pkg::PH_HEADER;
    end else begin
      klen_r  <= klen_nxt;
      fwd_r   <= fwd_nxt;
      rev_r   <= rev_nxt;
      run_r   <= run_nxt;
      phase_r <= phase_nxt;
    end
  end

endmodule

// File: rtl/core/ckh_queue.sv
module ckh_queue #(
  parameter int unsigned DEPTH = ckh_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  ckh_pkg::entry_t    push_entry,
  input  logic               pop,
  output ckh_pkg::entry_t    head,
  output ckh_pkg::q_status_t stat
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  ckh_pkg::entry_t mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == FULL_CNT);
  assign stat.empty = (cnt_r == '0);
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL_CNT)
    else $error("queue occupancy above depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!stat.full || pop))
    else $error("request pushed into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !stat.empty)
    else $error("pop from empty queue");

  a_cnt_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("queue count did not advance on push");
`endif

endmodule

// File: rtl/core/ckh_hash.sv
module ckh_hash (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ckh_pkg::entry_t             head,
  input  ckh_pkg::q_status_t          q_stat,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [ckh_pkg::KMER_W-1:0]  out_kmer_hash,
  output logic [1:0]                  out_bucket
);

  localparam int unsigned KW = ckh_pkg::KMER_W;

  logic          adv;
  logic          v1_r, v2_r, v3_r, vo_r;
  logic [KW-1:0] d1_r, d2_r, d3_r, do_r;
  logic [KW-1:0] m1_r, m2_r, m3_r;
  logic [KW-1:0] t1, t2, t3;
  logic [KW-1:0] d1_nxt, d2_nxt, d3_nxt, do_nxt;

  // whole pipe moves unless the output holds an unaccepted request
  assign adv = !vo_r || !out_stall;
  assign pop = adv && !q_stat.empty;

  assign t1     = (~head.kmer + (head.kmer << 21)) & head.mask;
  assign d1_nxt = t1 ^ (t1 >> 24);
  assign t2     = (d1_r + (d1_r << 3) + (d1_r << 8)) & m1_r;
  assign d2_nxt = t2 ^ (t2 >> 14);
  assign t3     = (d2_r + (d2_r << 2) + (d2_r << 4)) & m2_r;
  assign d3_nxt = t3 ^ (t3 >> 28);
  assign do_nxt = (d3_r + (d3_r << 31)) & m3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      vo_r <= 1'b0;
    end else if (adv) begin
      v1_r <= !q_stat.empty;
      v2_r <= v1_r;
      v3_r <= v2_r;
      vo_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d1_r <= d1_nxt;
      m1_r <= head.mask;
      d2_r <= d2_nxt;
      m2_r <= m1_r;
      d3_r <= d3_nxt;
      m3_r <= m2_r;
      do_r <= do_nxt;
    end
  end

  assign out_valid     = vo_r;
  assign out_kmer_hash = do_r;
  assign out_bucket    = do_r[1:0];

endmodule

// File: rtl/core/canonical_kmer_hash_extractor.sv
// A completed k-mer's hash goes via the queue and d1_r, d2_r, d3_r, do_r to out_valid.
// Throughput: one byte per cycle unless in_stall; hash pipe of four stages behind a queue.
// in_stall rises only when the queue (QUEUE_DEPTH entries) is full, which happens
// only when out_stall holds the output back.
// Reset (rst_n, synchronous, active low): k = 31, header line, k-mers and queue cleared.
module canonical_kmer_hash_extractor #(
  parameter int unsigned QUEUE_DEPTH = ckh_pkg::QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ckh_pkg::KLEN_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_text_byte,
  input  logic                          in_end_of_buffer,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ckh_pkg::KMER_W-1:0]    out_kmer_hash,
  output logic [1:0]                    out_bucket
);

  ckh_pkg::q_status_t q_stat;
  ckh_pkg::entry_t    push_entry;
  ckh_pkg::entry_t    head;
  logic               push_valid;
  logic               pop;

  ckh_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_text_byte     (in_text_byte),
    .in_end_of_buffer (in_end_of_buffer),
    .q_stat           (q_stat),
    .push_valid       (push_valid),
    .push_entry       (push_entry)
  );

  ckh_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push_valid),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .stat       (q_stat)
  );

  ckh_hash u_hash (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (head),
    .q_stat        (q_stat),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_kmer_hash (out_kmer_hash),
    .out_bucket    (out_bucket)
  );

endmodule
